@@ hw/rtl/dtfp_pkg.sv @@
// dtfp_pkg: shared types and constants for the decimal text to fixed-point block.
// Holds character codes, parse phase codes, divider constants and the
// controller/datapath command and status structs. No dependencies.
package dtfp_pkg;

  // Character codes recognised by the parser.
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharZero  = 8'h30;

  // Decimal radix and rounding threshold.
  localparam logic [7:0] Ten       = 8'd10;
  localparam logic [3:0] RoundHalf = 4'd5;

  // Divide-by-ten unit: one nibble per cycle over a 36-bit dividend.
  // The quotient of a value below 160 is (x * Recip10) >> RecipShift.
  localparam int unsigned DivWidth   = 36;
  localparam int unsigned DivSteps   = DivWidth / 4;
  localparam logic [7:0]  Recip10    = 8'd205;
  localparam int unsigned RecipShift = 11;

  // Parse phase codes.
  localparam logic [2:0] PhSkipWs   = 3'd0;
  localparam logic [2:0] PhAtoiWs   = 3'd1;
  localparam logic [2:0] PhDigits   = 3'd2;
  localparam logic [2:0] PhSeekDot  = 3'd3;
  localparam logic [2:0] PhFraction = 3'd4;
  localparam logic [2:0] PhDone     = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic parse;   // a character beat is accepted
    logic start;   // latch factor magnitude and sign, reset the fold
    logic rd;      // read the next fraction digit, counting down
    logic mac;     // fold sum = m + magnitude * digit
    logic div;     // one nibble step of the divide by ten
    logic commit;  // take quotient and rounding bit
    logic wmul;    // whole part times magnitude
    logic sum;     // signed whole product plus fraction
    logic load;    // load the result register and clear parse state
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_zero;  // no fraction digits left to fold
  } sts_t;

endpackage

@@ hw/rtl/decimal_text_to_fixed_point.sv @@
// decimal_text_to_fixed_point: top level, joining controller and datapath.
// Depends on dtfp_pkg, dtfp_ctrl and dtfp_datapath.
//
//   Channel   Handshake              Payload
//   in        in_valid / in_ready    in_text_char[7:0], in_last_char
//   out       out_valid / out_ready  out_fixed_value[31:0], out_overflow,
//                                    out_fraction_truncated
//   cfg       cfg_wr_en              cfg_wr_data[31:0] (scale factor)
//
// Ordinary characters are taken one per cycle. A beat carrying the last-char
// mark is followed by work on the N stored fraction digits: each digit
// takes a memory read, a multiply-add and the nibble-serial divide by ten.
// The result then sits in an output register, and the next string may start
// while it waits. Reset is synchronous and active low; the scale factor
// resets to 1.
module decimal_text_to_fixed_point #(
  parameter int FRAC_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_text_char,
  input  logic               in_last_char,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_fixed_value,
  output logic               out_overflow,
  output logic               out_fraction_truncated,
  input  logic               cfg_wr_en,
  input  logic signed [31:0] cfg_wr_data
);

  dtfp_pkg::cmd_t cmd;
  dtfp_pkg::sts_t sts;

  // Sequencing.
  dtfp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_char (in_last_char),
    .in_ready     (in_ready),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Parsing, folding and scaling.
  dtfp_datapath #(
    .FRAC_DEPTH (FRAC_DEPTH)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .in_text_char           (in_text_char),
    .out_fixed_value        (out_fixed_value),
    .out_overflow           (out_overflow),
    .out_fraction_truncated (out_fraction_truncated)
  );

endmodule

@@ hw/rtl/dtfp_ctrl.sv @@
// dtfp_ctrl: controller state machine for the decimal text to fixed-point block.
// Sequences parsing, the backward fraction fold and the final scaling.
// Depends on dtfp_pkg.
module dtfp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last_char,
  output logic           in_ready,
  input  logic           out_ready,
  output logic           out_valid,
  input  dtfp_pkg::sts_t sts,
  output dtfp_pkg::cmd_t cmd
);

  localparam logic [3:0] S_PARSE  = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_NEXT   = 4'd2;
  localparam logic [3:0] S_RADDR  = 4'd3;
  localparam logic [3:0] S_MAC    = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_COMMIT = 4'd6;
  localparam logic [3:0] S_WMUL   = 4'd7;
  localparam logic [3:0] S_SUM    = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  localparam int unsigned StepW = $clog2(dtfp_pkg::DivSteps);
  localparam logic [StepW-1:0] LastStep = StepW'(dtfp_pkg::DivSteps - 1);

  logic [3:0]       state_r, state_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             slot_free;

  // Characters are taken only while parsing.
  assign in_ready  = (state_r == S_PARSE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      S_PARSE: begin
        cmd.parse = accept;
        if (accept && in_last_char) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        state_nxt = sts.idx_zero ? S_WMUL : S_RADDR;
      end
      S_RADDR: begin
        cmd.rd    = 1'b1;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        cmd.mac   = 1'b1;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div  = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == LastStep) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_NEXT;
      end
      S_WMUL: begin
        cmd.wmul  = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // Wait for the result register to be free.
        if (slot_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_PARSE;
        end
      end
      default: begin
        state_nxt = S_PARSE;
      end
    endcase
  end

  // Result beat valid flag.
  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_PARSE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hw/rtl/dtfp_datapath.sv @@
// dtfp_datapath: parser registers, fraction digit memory, fold unit with a
// nibble-serial divide by ten, scaling multiplier and result register.
// Depends on dtfp_pkg; driven by dtfp_ctrl.
module dtfp_datapath #(
  parameter int FRAC_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dtfp_pkg::cmd_t     cmd,
  output dtfp_pkg::sts_t     sts,
  input  logic               cfg_wr_en,
  input  logic signed [31:0] cfg_wr_data,
  input  logic [7:0]         in_text_char,
  output logic signed [31:0] out_fixed_value,
  output logic               out_overflow,
  output logic               out_fraction_truncated
);

  localparam int unsigned CW = $clog2(FRAC_DEPTH + 1);
  localparam int unsigned AW = (FRAC_DEPTH > 1) ? $clog2(FRAC_DEPTH) : 1;
  localparam int unsigned DW = dtfp_pkg::DivWidth;

  // Configuration register.
  logic signed [31:0] scale_r;

  // Parse state.
  logic [2:0]    phase_r, phase_nxt;
  logic          minus_r, minus_nxt;
  logic          wsn_r, wsn_nxt;
  logic [31:0]   accum_r, accum_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          drop_r, drop_nxt;
  logic          ovfs_r, ovfs_nxt;
  logic          fwr_en;

  // Fraction digit memory.
  logic [3:0] frac_mem [FRAC_DEPTH];
  logic [3:0] rd_data_r;

  // Fold and scaling registers.
  logic [31:0]   mag_r;
  logic          neg_r;
  logic [CW-1:0] idx_r;
  logic [31:0]   m_r;
  logic          rnd_r;
  logic [DW-1:0] sum_r;
  logic [3:0]    rem_r;
  logic [63:0]   prod_r;
  logic [63:0]   t_r;

  // Result registers.
  logic signed [31:0] value_r;
  logic               ovf_r;
  logic               trunc_r;

  // Character classification.
  logic [7:0]  c;
  logic [7:0]  c_off;
  logic [3:0]  digit;
  logic        is_digit;
  logic        is_space;
  logic        is_nul;
  logic [2:0]  ph;
  logic        go;
  logic [35:0] whole_v;
  logic [35:0] whole_lim;

  assign c        = in_text_char;
  assign c_off    = c - dtfp_pkg::CharZero;
  assign digit    = c_off[3:0];
  assign is_digit = (c_off < dtfp_pkg::Ten);
  assign is_nul   = (c == dtfp_pkg::CharNul);
  assign is_space = (c == dtfp_pkg::CharSpace) ||
                    ((c >= dtfp_pkg::CharTab) && (c <= dtfp_pkg::CharCr));

  // Whole part digit: accum * 10 + digit, saturated at the signed limit.
  assign whole_v   = (36'(accum_r) << 3) + (36'(accum_r) << 1) + 36'(digit);
  assign whole_lim = wsn_r ? 36'h080000000 : 36'h07fffffff;

  // Character parser: phases fall through to the next one as in atoi.
  always_comb begin
    ph        = phase_r;
    go        = (phase_r != dtfp_pkg::PhDone);
    phase_nxt = phase_r;
    minus_nxt = minus_r;
    wsn_nxt   = wsn_r;
    accum_nxt = accum_r;
    count_nxt = count_r;
    drop_nxt  = drop_r;
    ovfs_nxt  = ovfs_r;
    fwr_en    = 1'b0;
    if (go && ph == dtfp_pkg::PhSkipWs) begin
      if (is_nul) begin
        phase_nxt = dtfp_pkg::PhDone;
        go        = 1'b0;
      end else if (is_space) begin
        go = 1'b0;
      end else if (c == dtfp_pkg::CharMinus) begin
        minus_nxt = 1'b1;
        phase_nxt = dtfp_pkg::PhAtoiWs;
        go        = 1'b0;
      end else begin
        ph = dtfp_pkg::PhAtoiWs;
      end
    end
    if (go && ph == dtfp_pkg::PhAtoiWs) begin
      if (is_nul) begin
        phase_nxt = dtfp_pkg::PhDone;
        go        = 1'b0;
      end else if (is_space) begin
        phase_nxt = dtfp_pkg::PhAtoiWs;
        go        = 1'b0;
      end else if (c == dtfp_pkg::CharPlus || c == dtfp_pkg::CharMinus) begin
        wsn_nxt   = (c == dtfp_pkg::CharMinus);
        phase_nxt = dtfp_pkg::PhDigits;
        go        = 1'b0;
      end else begin
        ph = dtfp_pkg::PhDigits;
      end
    end
    if (go && ph == dtfp_pkg::PhDigits) begin
      if (is_digit) begin
        phase_nxt = dtfp_pkg::PhDigits;
        go        = 1'b0;
        if (whole_v > whole_lim) begin
          accum_nxt = whole_lim[31:0];
          ovfs_nxt  = 1'b1;
        end else begin
          accum_nxt = whole_v[31:0];
        end
      end else begin
        ph = dtfp_pkg::PhSeekDot;
      end
    end
    if (go && ph == dtfp_pkg::PhSeekDot) begin
      go = 1'b0;
      if (is_nul) begin
        phase_nxt = dtfp_pkg::PhDone;
      end else if (c == dtfp_pkg::CharDot) begin
        phase_nxt = dtfp_pkg::PhFraction;
      end else begin
        phase_nxt = dtfp_pkg::PhSeekDot;
      end
    end
    if (go && ph == dtfp_pkg::PhFraction) begin
      if (is_digit) begin
        if (count_r < CW'(FRAC_DEPTH)) begin
          fwr_en    = 1'b1;
          count_nxt = count_r + 1'b1;
        end else begin
          drop_nxt = 1'b1;
        end
      end else begin
        phase_nxt = dtfp_pkg::PhDone;
      end
    end
  end

  // Configuration and parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 32'sd1;
      phase_r <= dtfp_pkg::PhSkipWs;
      minus_r <= 1'b0;
      wsn_r   <= 1'b0;
      accum_r <= '0;
      count_r <= '0;
      drop_r  <= 1'b0;
      ovfs_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        scale_r <= cfg_wr_data;
      end
      if (cmd.load) begin
        phase_r <= dtfp_pkg::PhSkipWs;
        minus_r <= 1'b0;
        wsn_r   <= 1'b0;
        accum_r <= '0;
        count_r <= '0;
        drop_r  <= 1'b0;
        ovfs_r  <= 1'b0;
      end else if (cmd.parse) begin
        phase_r <= phase_nxt;
        minus_r <= minus_nxt;
        wsn_r   <= wsn_nxt;
        accum_r <= accum_nxt;
        count_r <= count_nxt;
        drop_r  <= drop_nxt;
        ovfs_r  <= ovfs_nxt;
      end
    end
  end

  // Fraction digit memory: written while parsing, read back last digit first.
  logic [CW-1:0] idx_m1;
  assign idx_m1 = idx_r - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.parse && fwr_en) begin
      frac_mem[count_r[AW-1:0]] <= digit;
    end
    if (cmd.rd) begin
      rd_data_r <= frac_mem[idx_m1[AW-1:0]];
    end
  end

  assign sts.idx_zero = (idx_r == '0);

  // Divide-by-ten step on the top nibble of the dividend.
  logic [7:0]  dv_x;
  logic [15:0] dv_mul;
  logic [3:0]  dv_q;
  logic [7:0]  dv_r;
  logic [35:0] mac_prod;

  assign dv_x     = {rem_r, sum_r[DW-1 -: 4]};
  assign dv_mul   = 16'(dv_x) * 16'(dtfp_pkg::Recip10);
  assign dv_q     = dv_mul[dtfp_pkg::RecipShift +: 4];
  assign dv_r     = dv_x - (8'(dv_q) * dtfp_pkg::Ten);
  assign mac_prod = 36'(mag_r) * 36'(rd_data_r);

  // Fold and scaling pipeline.
  logic [63:0] t_signed;
  logic [63:0] fin;
  logic        fits;

  assign t_signed = (wsn_r ? (64'd0 - prod_r) : prod_r) + 64'(m_r) + 64'(rnd_r);
  assign fin      = neg_r ? (64'd0 - t_r) : t_r;
  assign fits     = (fin[63:31] == '0) || (fin[63:31] == '1);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mag_r <= scale_r[31] ? (32'd0 - scale_r) : scale_r;
      neg_r <= minus_r ^ scale_r[31];
      idx_r <= count_r;
      m_r   <= '0;
      rnd_r <= 1'b0;
    end
    if (cmd.rd) begin
      idx_r <= idx_m1;
    end
    if (cmd.mac) begin
      sum_r <= DW'(m_r) + mac_prod;
      rem_r <= '0;
    end
    if (cmd.div) begin
      sum_r <= {sum_r[DW-5:0], dv_q};
      rem_r <= dv_r[3:0];
    end
    if (cmd.commit) begin
      m_r   <= sum_r[31:0];
      rnd_r <= (rem_r >= dtfp_pkg::RoundHalf);
    end
    if (cmd.wmul) begin
      prod_r <= 64'(accum_r) * 64'(mag_r);
    end
    if (cmd.sum) begin
      t_r <= t_signed;
    end
  end

  // Result register; a zero factor forces zero with no overflow.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      trunc_r <= drop_r;
      if (mag_r == '0) begin
        value_r <= '0;
        ovf_r   <= 1'b0;
      end else if (fits) begin
        value_r <= fin[31:0];
        ovf_r   <= ovfs_r;
      end else begin
        value_r <= fin[63] ? 32'sh80000000 : 32'sh7fffffff;
        ovf_r   <= 1'b1;
      end
    end
  end

  assign out_fixed_value        = value_r;
  assign out_overflow           = ovf_r;
  assign out_fraction_truncated = trunc_r;

endmodule

@@ hw/rtl/dtfp_checker.sv @@
// dtfp_checker: port-level assertions for decimal_text_to_fixed_point,
// attached by the bind statement at the end of this file.
// Depends only on the top level's ports.
module dtfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_char,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_fixed_value,
  input logic        out_overflow,
  input logic        out_fraction_truncated
);

  // The block goes busy once the closing character of a string is taken.
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_char |=> !in_ready)
    else $error("input still ready after the closing character");

  // A new result appears only at the end of a busy period.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a preceding busy period");

  // A result beat with no closing character taken in between cannot appear
  // right after an idle cycle with the output empty.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_ready && !(in_valid && in_last_char) |=> !out_valid)
    else $error("result appeared without a closing character");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fixed_value) &&
      $stable(out_overflow) && $stable(out_fraction_truncated))
    else $error("stalled result beat changed");

endmodule

bind decimal_text_to_fixed_point dtfp_checker u_dtfp_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_valid),
  .in_ready               (in_ready),
  .in_last_char           (in_last_char),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_fixed_value        (out_fixed_value),
  .out_overflow           (out_overflow),
  .out_fraction_truncated (out_fraction_truncated)
);
